// ----- rtl/four_point_sphere_fit_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sphere fit core
// Clocked concurrent checks on aclk; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FOUR_POINT_SPHERE_FIT_CORE_DEFINES_SVH
`define FOUR_POINT_SPHERE_FIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// check while out of reset
`define FSPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check that also covers the reset cycles
`define FSPF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FSPF_ASSERT(lbl, prop, msg)
`define FSPF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/fspf_pkg.sv -----
// ---------------------------------------------------------------------------
// Sphere fit package
// Item types, datapath widths and the threshold reset value.
// ---------------------------------------------------------------------------
package fspf_pkg;

    localparam int COORD_BITS  = 24;
    localparam int FRAC_BITS   = 13;
    localparam int MINVOL_BITS = 48;

    // 0.01 cubed-metre threshold, rounded, clipped to the register width
    localparam logic [63:0] MINVOL_RAW =
        ((64'd1 << (3 * FRAC_BITS)) + 64'd50) / 64'd100;
    localparam logic [MINVOL_BITS-1:0] MINVOL_RESET =
        (MINVOL_RAW > {{(64-MINVOL_BITS){1'b0}}, {MINVOL_BITS{1'b1}}}) ?
        {MINVOL_BITS{1'b1}} : MINVOL_RAW[MINVOL_BITS-1:0];

    localparam int DW   = COORD_BITS + 1;     // edge vector component
    localparam int SQW  = 2 * DW;             // product of two components
    localparam int SW   = 2 * DW;             // squared edge length, unsigned
    localparam int CW   = 2 * DW + 1;         // 2x2 cofactor
    localparam int DETW = DW + CW + 2;        // triple product
    localparam int NW   = SW + CW + 3;        // Cramer numerator
    localparam int QW   = COORD_BITS + 1;     // quotient bits kept
    localparam int XW   = NW + QW;            // divider remainder
    localparam int RXW  = 2 * COORD_BITS + 2; // sum of squared offsets
    localparam int RW   = COORD_BITS + 1;     // square root result
    localparam int RYW  = RXW + 1;            // square root remainder

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p0_z;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p1_z;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p2_z;
        coord_t p3_x;
        coord_t p3_y;
        coord_t p3_z;
    } in_item_t;

    typedef struct packed {
        coord_t                  center_x;
        coord_t                  center_y;
        coord_t                  center_z;
        logic [COORD_BITS-1:0]   radius;
        logic                    valid_res;
        logic                    saturated;
    } out_item_t;

    // side data that rides along the divider
    typedef struct packed {
        logic         coplanar;
        logic [2:0]   fits;
        logic [2:0]   negq;
        coord_t [2:0] p0;
    } div_side_t;

    // side data that rides along the square root
    typedef struct packed {
        logic         coplanar;
        coord_t [2:0] center;
        logic         sat;
        logic         rad_ok;
    } root_side_t;

    // rows/columns left over for the minor of row or column i
    function automatic logic [1:0] minor_lo(input logic [1:0] i);
        return (i == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] minor_hi(input logic [1:0] i);
        return (i == 2'd2) ? 2'd1 : 2'd2;
    endfunction

endpackage

// ----- rtl/four_point_sphere_fit_core.sv -----
// ---------------------------------------------------------------------------
// Sphere through four points
// Fits the sphere through four 3-D points with a pipelined Cramer solver.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one item of four points (s_item); m_valid/m_ready
//   return one result per item (m_item): centre, radius and flags.
//   cfg_wr_en/cfg_wr_data load the coplanarity threshold min_volume; write it
//   only while no item is in flight.
//   The pipeline computes edge vectors, cofactors, split multiplies and
//   abs/compare, then runs the divider, the offsets and squares and the
//   square root, then the output register.
//   Throughput is one item per cycle; every stage is a register stage.
//   The whole pipeline advances when the output register is empty or taken,
//   so a stalled receiver holds every item in place and s_ready drops.
//   Reset clears all valid bits and loads min_volume with 0.01 cubic metres.
//   Coplanar points give an all-zero result with valid_res low.
// ---------------------------------------------------------------------------
`include "four_point_sphere_fit_core_defines.svh"

module four_point_sphere_fit_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fspf_pkg::MINVOL_BITS-1:0]   cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fspf_pkg::in_item_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fspf_pkg::out_item_t                m_item
);

    localparam int CB   = fspf_pkg::COORD_BITS;
    localparam int DW   = fspf_pkg::DW;
    localparam int SQW  = fspf_pkg::SQW;
    localparam int SW   = fspf_pkg::SW;
    localparam int CW   = fspf_pkg::CW;
    localparam int DETW = fspf_pkg::DETW;
    localparam int NW   = fspf_pkg::NW;
    localparam int QW   = fspf_pkg::QW;
    localparam int XW   = fspf_pkg::XW;
    localparam int RXW  = fspf_pkg::RXW;
    localparam int RW   = fspf_pkg::RW;
    localparam int OW   = CB + 3;

    localparam logic signed [OW-1:0] SUM_MAX = {4'b0000, {(CB-1){1'b1}}};
    localparam logic signed [OW-1:0] SUM_MIN = {4'b1111, {(CB-1){1'b0}}};

    logic en;
    logic [fspf_pkg::MINVOL_BITS-1:0] min_volume_reg;

    fspf_pkg::coord_t pt [4][3];
    fspf_pkg::coord_t p0_pipe_reg [7][3];
    logic [7:0]       v_reg;

    logic signed [DW-1:0]    d1_reg   [3][3];
    logic signed [SQW-1:0]   sq2_reg  [3][3];
    logic signed [SQW-1:0]   sq2_next [3][3];
    logic signed [SQW-1:0]   pa2_reg  [3][3];
    logic signed [SQW-1:0]   pa2_next [3][3];
    logic signed [SQW-1:0]   pb2_reg  [3][3];
    logic signed [SQW-1:0]   pb2_next [3][3];
    logic signed [DW-1:0]    dc2_reg  [3];
    logic signed [DW-1:0]    dc3_reg  [3];
    logic [SW-1:0]           s3_reg   [3];
    logic [SW-1:0]           s3_next  [3];
    logic signed [CW-1:0]    cof3_reg [3][3];
    logic signed [CW-1:0]    cof3_next[3][3];
    logic signed [DW+CW-1:0] dp5      [3];
    logic signed [SW+CW:0]   np5      [3][3];
    logic signed [DETW-1:0]  det6_reg;
    logic signed [NW-1:0]    n6_reg   [3];
    logic [DETW-1:0]         adet7_reg;
    logic [NW-1:0]           an7_reg  [3];
    logic [2:0]              negq7_reg;
    logic [NW-1:0]           an8_reg  [3];
    logic [DETW:0]           den8_reg;
    fspf_pkg::div_side_t     side8_reg;
    fspf_pkg::div_side_t     side8_next;

    logic                    dv_valid;
    logic [QW-1:0]           dq [3];
    fspf_pkg::div_side_t     dside;

    fspf_pkg::root_side_t    side_p_reg;
    fspf_pkg::root_side_t    side_p_next;
    logic [CB-1:0]           mag_p_reg [3];
    logic                    vp_reg;
    fspf_pkg::root_side_t    side_q_reg;
    logic [2*CB-1:0]         sq_q_reg  [3];
    logic                    vq_reg;
    fspf_pkg::root_side_t    side_r_reg;
    logic [RXW-1:0]          x_r_reg;
    logic                    vr_reg;

    logic                    rt_valid;
    logic [RW-1:0]           rt_root;
    fspf_pkg::root_side_t    rt_side;

    logic                    m_valid_reg;
    fspf_pkg::out_item_t     m_item_reg;
    fspf_pkg::out_item_t     m_item_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_volume_reg <= fspf_pkg::MINVOL_RESET;
        end else if (cfg_wr_en) begin
            min_volume_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], s_valid};
        end
    end

    assign pt[0][0] = s_item.p0_x;
    assign pt[0][1] = s_item.p0_y;
    assign pt[0][2] = s_item.p0_z;
    assign pt[1][0] = s_item.p1_x;
    assign pt[1][1] = s_item.p1_y;
    assign pt[1][2] = s_item.p1_z;
    assign pt[2][0] = s_item.p2_x;
    assign pt[2][1] = s_item.p2_y;
    assign pt[2][2] = s_item.p2_z;
    assign pt[3][0] = s_item.p3_x;
    assign pt[3][1] = s_item.p3_y;
    assign pt[3][2] = s_item.p3_z;

    // edge vectors and first-point delay line
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    d1_reg[i][j] <= DW'(pt[i+1][j]) - DW'(pt[0][j]);
                end
                p0_pipe_reg[0][i] <= pt[0][i];
            end
            for (int k = 1; k < 7; k++) begin
                for (int i = 0; i < 3; i++) begin
                    p0_pipe_reg[k][i] <= p0_pipe_reg[k-1][i];
                end
            end
        end
    end

    // squares and the two products of every 2x2 minor
    always_comb begin
        logic [1:0] rl, rh, cl, ch;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rl = fspf_pkg::minor_lo(2'(i));
                rh = fspf_pkg::minor_hi(2'(i));
                cl = fspf_pkg::minor_lo(2'(j));
                ch = fspf_pkg::minor_hi(2'(j));
                sq2_next[i][j] = d1_reg[i][j] * d1_reg[i][j];
                pa2_next[i][j] = d1_reg[rl][cl] * d1_reg[rh][ch];
                pb2_next[i][j] = d1_reg[rl][ch] * d1_reg[rh][cl];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq2_reg <= sq2_next;
            pa2_reg <= pa2_next;
            pb2_reg <= pb2_next;
            for (int i = 0; i < 3; i++) begin
                dc2_reg[i] <= d1_reg[i][0];
            end
        end
    end

    // squared lengths and signed cofactors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_next[i] = SW'(sq2_reg[i][0]) + SW'(sq2_reg[i][1]) + SW'(sq2_reg[i][2]);
            for (int j = 0; j < 3; j++) begin
                if (((i + j) & 1) != 0) begin
                    cof3_next[i][j] = CW'(pb2_reg[i][j]) - CW'(pa2_reg[i][j]);
                end else begin
                    cof3_next[i][j] = CW'(pa2_reg[i][j]) - CW'(pb2_reg[i][j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg   <= s3_next;
            cof3_reg <= cof3_next;
            dc3_reg  <= dc2_reg;
        end
    end

    // determinant along column 0, numerators along the s column
    for (genvar i = 0; i < 3; i++) begin : g_row
        fspf_mul #(.AW(DW), .BW(CW)) u_det_mul (
            .aclk (aclk),
            .en   (en),
            .a    (dc3_reg[i]),
            .b    (cof3_reg[i][0]),
            .p    (dp5[i])
        );
        for (genvar j = 0; j < 3; j++) begin : g_col
            fspf_mul #(.AW(SW+1), .BW(CW)) u_num_mul (
                .aclk (aclk),
                .en   (en),
                .a    ($signed({1'b0, s3_reg[i]})),
                .b    (cof3_reg[i][j]),
                .p    (np5[i][j])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det6_reg <= DETW'(dp5[0]) + DETW'(dp5[1]) + DETW'(dp5[2]);
            for (int j = 0; j < 3; j++) begin
                n6_reg[j] <= NW'(np5[0][j]) + NW'(np5[1][j]) + NW'(np5[2][j]);
            end
        end
    end

    // magnitudes and quotient signs
    always_ff @(posedge aclk) begin
        if (en) begin
            adet7_reg <= det6_reg[DETW-1] ? DETW'(-det6_reg) : DETW'(det6_reg);
            for (int j = 0; j < 3; j++) begin
                an7_reg[j]   <= n6_reg[j][NW-1] ? NW'(-n6_reg[j]) : NW'(n6_reg[j]);
                negq7_reg[j] <= n6_reg[j][NW-1] ^ det6_reg[DETW-1];
            end
        end
    end

    // coplanarity gate and quotient range check
    always_comb begin
        side8_next.coplanar = adet7_reg <= DETW'(min_volume_reg);
        side8_next.negq     = negq7_reg;
        for (int j = 0; j < 3; j++) begin
            side8_next.fits[j] = XW'(an7_reg[j]) < (XW'({adet7_reg, 1'b0}) << QW);
            side8_next.p0[j]   = p0_pipe_reg[6][j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            an8_reg   <= an7_reg;
            den8_reg  <= {adet7_reg, 1'b0};
            side8_reg <= side8_next;
        end
    end

    fspf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[7]),
        .num       (an8_reg),
        .den       (den8_reg),
        .side_in   (side8_reg),
        .out_valid (dv_valid),
        .quo       (dq),
        .side_out  (dside)
    );

    // centre = first point + signed offset, clipped
    always_comb begin
        logic signed [QW:0]   off;
        logic signed [OW-1:0] sum;
        side_p_next.coplanar = dside.coplanar;
        side_p_next.sat      = 1'b0;
        side_p_next.rad_ok   = 1'b1;
        for (int j = 0; j < 3; j++) begin
            off = dside.negq[j] ? -$signed({1'b0, dq[j]}) : $signed({1'b0, dq[j]});
            sum = OW'($signed(dside.p0[j])) + OW'(off);
            if (!dside.fits[j]) begin
                side_p_next.center[j] = dside.negq[j] ? SUM_MIN[CB-1:0] : SUM_MAX[CB-1:0];
                side_p_next.sat       = 1'b1;
                side_p_next.rad_ok    = 1'b0;
            end else if (sum > SUM_MAX) begin
                side_p_next.center[j] = SUM_MAX[CB-1:0];
                side_p_next.sat       = 1'b1;
            end else if (sum < SUM_MIN) begin
                side_p_next.center[j] = SUM_MIN[CB-1:0];
                side_p_next.sat       = 1'b1;
            end else begin
                side_p_next.center[j] = sum[CB-1:0];
            end
            if (dq[j][QW-1]) begin
                side_p_next.rad_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
            vr_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= dv_valid;
            vq_reg <= vp_reg;
            vr_reg <= vq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p_reg <= side_p_next;
            for (int j = 0; j < 3; j++) begin
                mag_p_reg[j] <= dq[j][CB-1:0];
                sq_q_reg[j]  <= mag_p_reg[j] * mag_p_reg[j];
            end
            side_q_reg <= side_p_reg;
            x_r_reg    <= RXW'(sq_q_reg[0]) + RXW'(sq_q_reg[1]) + RXW'(sq_q_reg[2]);
            side_r_reg <= side_q_reg;
        end
    end

    fspf_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vr_reg),
        .x         (x_r_reg),
        .side_in   (side_r_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .side_out  (rt_side)
    );

    always_comb begin
        m_item_next = '0;
        if (!rt_side.coplanar) begin
            m_item_next.center_x  = rt_side.center[0];
            m_item_next.center_y  = rt_side.center[1];
            m_item_next.center_z  = rt_side.center[2];
            m_item_next.valid_res = 1'b1;
            if (!rt_side.rad_ok || rt_root[RW-1]) begin
                m_item_next.radius    = '1;
                m_item_next.saturated = 1'b1;
            end else begin
                m_item_next.radius    = rt_root[CB-1:0];
                m_item_next.saturated = rt_side.sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `FSPF_ASSERT(a_coplanar_zero, m_valid_reg && !m_item_reg.valid_res |-> m_item_reg == '0, "coplanar result not cleared")
    `FSPF_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid_reg && !vr_reg && v_reg == '0, "pipeline not empty after reset")

endmodule

// ----- rtl/fspf_mul.sv -----
// ---------------------------------------------------------------------------
// Two-stage signed multiplier
// Splits both operands in halves; partial products, then their sum.
// ---------------------------------------------------------------------------
module fspf_mul #(
    parameter int AW = 25,
    parameter int BW = 51
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic signed [AL:0]   al;
    logic signed [AH-1:0] ah;
    logic signed [BL:0]   bl;
    logic signed [BH-1:0] bh;

    logic signed [AL+BL+1:0] ll_reg;
    logic signed [AL+BH:0]   lh_reg;
    logic signed [AH+BL:0]   hl_reg;
    logic signed [AH+BH-1:0] hh_reg;
    logic signed [PW-1:0]    p_reg;
    logic signed [PW-1:0]    p_next;

    assign al = $signed({1'b0, a[AL-1:0]});
    assign ah = $signed(a[AW-1:AL]);
    assign bl = $signed({1'b0, b[BL-1:0]});
    assign bh = $signed(b[BW-1:BL]);

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= al * bl;
            lh_reg <= al * bh;
            hl_reg <= ah * bl;
            hh_reg <= ah * bh;
            p_reg  <= p_next;
        end
    end

    always_comb begin
        p_next = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
               + (PW'(hh_reg) << (AL + BL));
    end

    assign p = p_reg;

endmodule

// ----- rtl/fspf_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division, one quotient bit per stage for all three numerators.
// ---------------------------------------------------------------------------
`include "four_point_sphere_fit_core_defines.svh"

module fspf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [fspf_pkg::NW-1:0]       num [3],
    input  logic [fspf_pkg::DETW:0]       den,
    input  fspf_pkg::div_side_t           side_in,
    output logic                          out_valid,
    output logic [fspf_pkg::QW-1:0]       quo [3],
    output fspf_pkg::div_side_t           side_out
);

    localparam int QW  = fspf_pkg::QW;
    localparam int XW  = fspf_pkg::XW;
    localparam int DNW = fspf_pkg::DETW + 1;

    logic [XW-1:0]       rem_in  [QW][3];
    logic [XW-1:0]       rem_nx  [QW][3];
    logic [XW-1:0]       rem_reg [QW][3];
    logic [QW-1:0]       q_in    [QW][3];
    logic [QW-1:0]       q_nx    [QW][3];
    logic [QW-1:0]       q_reg   [QW][3];
    logic [DNW-1:0]      den_in  [QW];
    logic [DNW-1:0]      den_reg [QW];
    fspf_pkg::div_side_t side_s  [QW];
    fspf_pkg::div_side_t side_reg[QW];
    logic                v_in    [QW];
    logic                v_reg   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;
        if (s == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[s][j] = XW'(num[j]);
                assign q_in[s][j]   = '0;
            end
            assign den_in[s] = den;
            assign side_s[s] = side_in;
            assign v_in[s]   = in_valid;
        end else begin : g_next
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[s][j] = rem_reg[s-1][j];
                assign q_in[s][j]   = q_reg[s-1][j];
            end
            assign den_in[s] = den_reg[s-1];
            assign side_s[s] = side_reg[s-1];
            assign v_in[s]   = v_reg[s-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_step
            // subtract the shifted divisor where it fits
            assign rem_nx[s][j] = (rem_in[s][j] >= (XW'(den_in[s]) << K)) ?
                                  rem_in[s][j] - (XW'(den_in[s]) << K) : rem_in[s][j];
            assign q_nx[s][j]   = q_in[s][j] |
                (QW'(rem_in[s][j] >= (XW'(den_in[s]) << K)) << K);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    rem_reg[s][j] <= rem_nx[s][j];
                    q_reg[s][j]   <= q_nx[s][j];
                end
                den_reg[s]  <= den_in[s];
                side_reg[s] <= side_s[s];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign side_out  = side_reg[QW-1];
    for (genvar j = 0; j < 3; j++) begin : g_out
        assign quo[j] = q_reg[QW-1][j];
    end

    `FSPF_ASSERT(a_div_rem_x, out_valid && side_out.fits[0] |-> rem_reg[QW-1][0] < XW'(den_reg[QW-1]), "x remainder not below divisor")
    `FSPF_ASSERT(a_div_rem_z, out_valid && side_out.fits[2] |-> rem_reg[QW-1][2] < XW'(den_reg[QW-1]), "z remainder not below divisor")

endmodule

// ----- rtl/fspf_isqrt.sv -----
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, remainder kept alongside.
// ---------------------------------------------------------------------------
`include "four_point_sphere_fit_core_defines.svh"

module fspf_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [fspf_pkg::RXW-1:0]  x,
    input  fspf_pkg::root_side_t      side_in,
    output logic                      out_valid,
    output logic [fspf_pkg::RW-1:0]   root,
    output fspf_pkg::root_side_t      side_out
);

    localparam int RW  = fspf_pkg::RW;
    localparam int RYW = fspf_pkg::RYW;

    logic [RYW-1:0]       rem_in   [RW];
    logic [RYW-1:0]       rem_reg  [RW];
    logic [RYW-1:0]       trial    [RW];
    logic [RW-1:0]        root_in  [RW];
    logic [RW-1:0]        root_reg [RW];
    fspf_pkg::root_side_t side_s   [RW];
    fspf_pkg::root_side_t side_reg [RW];
    logic                 v_in     [RW];
    logic                 v_reg    [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int K = RW - 1 - s;
        if (s == 0) begin : g_first
            assign rem_in[s]  = RYW'(x);
            assign root_in[s] = '0;
            assign side_s[s]  = side_in;
            assign v_in[s]    = in_valid;
        end else begin : g_next
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
            assign side_s[s]  = side_reg[s-1];
            assign v_in[s]    = v_reg[s-1];
        end

        // (root + 2^K)^2 - root^2
        assign trial[s] = (RYW'(root_in[s]) << (K + 1)) + (RYW'(1'b1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in[s] >= trial[s]) begin
                    rem_reg[s]  <= rem_in[s] - trial[s];
                    root_reg[s] <= root_in[s] | (RW'(1'b1) << K);
                end else begin
                    rem_reg[s]  <= rem_in[s];
                    root_reg[s] <= root_in[s];
                end
                side_reg[s] <= side_s[s];
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

    `FSPF_ASSERT(a_sqrt_floor, out_valid |-> rem_reg[RW-1] <= (RYW'(root_reg[RW-1]) << 1), "square root remainder too large")

endmodule
